// File: rtl/core/pfd_pkg.sv
// ----------------------------------------------------------------------------
// pfd_pkg: shared constants and types of the phi accrual failure detector
// Field widths, the log10(e) scale factor, register reset value and the
// sequencer state encoding.
// ----------------------------------------------------------------------------
package pfd_pkg;

  // default number of intervals held in the window
  localparam int unsigned WINDOW = 16;

  // field widths
  localparam int unsigned TIME_W = 48;
  localparam int unsigned IV_W   = 32;
  localparam int unsigned THR_W  = 16;

  // threshold is Q8.8, the product is compared against Q32 scaled terms,
  // so the threshold side carries 2^24 extra
  localparam int unsigned THR_SHIFT = 24;

  // log10(e) in Q32, fits 31 bits
  localparam int unsigned LOG10E_W = 31;
  localparam logic [LOG10E_W-1:0] LOG10E_Q32 = 31'd1865280597;

  // threshold reset value, 8.0 in Q8.8
  localparam logic [THR_W-1:0] THR_RESET = 16'd2048;

  // command codes
  localparam logic CMD_BEAT  = 1'b0;
  localparam logic CMD_CHECK = 1'b1;

  // sequencer states, one-hot
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_BEAT = 4'b0010,
    S_RUN  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

endpackage

// File: rtl/core/pfd_ram.sv
// ----------------------------------------------------------------------------
// pfd_ram: generic single write port RAM with registered read
// One write and one read address per cycle, read data in the cycle after the address.
// ----------------------------------------------------------------------------
module pfd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/core/phi_accrual_failure_detector.sv
// ----------------------------------------------------------------------------
// phi_accrual_failure_detector: heartbeat interval tracker and suspicion check
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------------
//   in      | input     | in_valid_i / in_stall_o | command_i, time_usec_i
//   out     | output    | out_valid_o/out_stall_i | suspect_o, intervals_held_o
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_data_i (phi_threshold_q8)
//
// One item at a time. A heartbeat passes the beat state to its result
// (straight to it while no heartbeat time is stored); an interval update
// reads the oldest ring entry through the registered RAM port. A check with
// no interval or a zero sum goes straight to the result. Other checks form
// both products of the cross-multiplied compare bit-serially over LW =
// 48 + 31 + clog2(Window + 1) bits (84 at Window 16), one product bit per
// cycle, compared lsb first. Reset clears the window at once (count and
// sum), no clearing pass. A finished result waits in the output register
// while the next beat is taken; the result state holds while that is stalled.
// ----------------------------------------------------------------------------
module phi_accrual_failure_detector #(
  parameter int unsigned Window = pfd_pkg::WINDOW
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input items
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               command_i,
  input  logic [pfd_pkg::TIME_W-1:0]         time_usec_i,
  // results
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               suspect_o,
  output logic [$clog2(Window+1)-1:0]        intervals_held_o,
  // threshold register write
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pfd_pkg::THR_W-1:0]          cfg_data_i
);

  localparam int unsigned CntW   = $clog2(Window + 1);
  localparam int unsigned SlotW  = $clog2(Window);
  localparam int unsigned SumW   = pfd_pkg::IV_W + $clog2(Window);
  localparam int unsigned KW     = pfd_pkg::LOG10E_W + CntW;
  localparam int unsigned LW     = pfd_pkg::TIME_W + KW;
  localparam int unsigned MrW    = pfd_pkg::THR_W + pfd_pkg::THR_SHIFT;
  localparam int unsigned BitCntW = $clog2(LW);

  pfd_pkg::state_e state_q, state_d;

  logic [pfd_pkg::THR_W-1:0]  thr_q;
  logic [SlotW-1:0]           slot_q, slot_d;
  logic [CntW-1:0]            count_q, count_d;
  logic [SumW-1:0]            sum_q, sum_d;
  logic [pfd_pkg::TIME_W-1:0] last_q, last_d;
  logic                       out_valid_q, out_valid_d;

  // datapath registers
  logic [pfd_pkg::IV_W-1:0]   iv_q, iv_d;
  logic [KW-1:0]              k_q, k_d;
  logic [pfd_pkg::TIME_W-1:0] ml_q, ml_d;
  logic [KW-1:0]              accl_q, accl_d;
  logic [MrW-1:0]             mr_q, mr_d;
  logic [SumW-1:0]            accr_q, accr_d;
  logic                       gt_q, gt_d;
  logic [BitCntW-1:0]         bit_cnt_q, bit_cnt_d;
  logic                       res_q, res_d;
  logic                       suspect_q;
  logic [CntW-1:0]            held_q;

  logic                       accept;
  logic                       out_load;
  logic [pfd_pkg::TIME_W-1:0] diff;
  logic [pfd_pkg::IV_W-1:0]   iv_sat;
  logic                       full;
  logic [KW:0]                suml;
  logic [SumW:0]              sumr;
  logic                       l_bit;
  logic                       r_bit;
  logic                       ram_we;
  logic [pfd_pkg::IV_W-1:0]   ram_rdata;

  assign cfg_ready_o      = 1'b1;
  assign in_stall_o       = (state_q != pfd_pkg::S_IDLE);
  assign accept           = in_valid_i && !in_stall_o;
  assign out_valid_o      = out_valid_q;
  assign suspect_o        = suspect_q;
  assign intervals_held_o = held_q;
  assign full             = (count_q == CntW'(Window));

  // time since the last beat, saturated to an interval
  assign diff   = time_usec_i - last_q;
  assign iv_sat = (|diff[pfd_pkg::TIME_W-1:pfd_pkg::IV_W]) ? '1 : diff[pfd_pkg::IV_W-1:0];

  // one step of each serial multiplier, product bits leave lsb first
  assign suml  = {1'b0, accl_q} + (ml_q[0] ? {1'b0, k_q} : '0);
  assign sumr  = {1'b0, accr_q} + (mr_q[0] ? {1'b0, sum_q} : '0);
  assign l_bit = suml[0];
  assign r_bit = sumr[0];

  // interval ring
  pfd_ram #(
    .Width (pfd_pkg::IV_W),
    .Depth (Window)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (iv_q),
    .raddr_i (slot_q),
    .rdata_o (ram_rdata)
  );

  assign out_load = (state_q == pfd_pkg::S_DONE) && (!out_valid_q || !out_stall_i);

  // sequencer and datapath next state
  always_comb begin
    state_d   = state_q;
    slot_d    = slot_q;
    count_d   = count_q;
    sum_d     = sum_q;
    last_d    = last_q;
    iv_d      = iv_q;
    k_d       = k_q;
    ml_d      = ml_q;
    accl_d    = accl_q;
    mr_d      = mr_q;
    accr_d    = accr_q;
    gt_d      = gt_q;
    bit_cnt_d = bit_cnt_q;
    res_d     = res_q;
    ram_we    = 1'b0;

    case (state_q)
      pfd_pkg::S_IDLE: begin
        // count times log10(e), kept ready for a check
        k_d = KW'(count_q) * KW'(pfd_pkg::LOG10E_Q32);
        if (accept) begin
          res_d = 1'b0;
          if (command_i == pfd_pkg::CMD_BEAT) begin
            last_d = time_usec_i;
            if (last_q == '0) begin
              state_d = pfd_pkg::S_DONE;
            end else begin
              iv_d    = iv_sat;
              state_d = pfd_pkg::S_BEAT;
            end
          end else begin
            if (count_q == '0 || sum_q == '0) begin
              state_d = pfd_pkg::S_DONE;
            end else begin
              ml_d      = diff;
              accl_d    = '0;
              mr_d      = {thr_q, {pfd_pkg::THR_SHIFT{1'b0}}};
              accr_d    = '0;
              gt_d      = 1'b0;
              bit_cnt_d = BitCntW'(LW - 1);
              state_d   = pfd_pkg::S_RUN;
            end
          end
        end
      end
      pfd_pkg::S_BEAT: begin
        // drop the oldest interval once the window is full
        sum_d  = sum_q - (full ? SumW'(ram_rdata) : '0) + SumW'(iv_q);
        ram_we = 1'b1;
        slot_d = (slot_q == SlotW'(Window - 1)) ? '0 : slot_q + 1'b1;
        if (!full) begin
          count_d = count_q + 1'b1;
        end
        state_d = pfd_pkg::S_DONE;
      end
      pfd_pkg::S_RUN: begin
        // shift-add step on both sides, compare lsb first
        accl_d = suml[KW:1];
        ml_d   = ml_q >> 1;
        accr_d = sumr[SumW:1];
        mr_d   = mr_q >> 1;
        if (l_bit != r_bit) begin
          gt_d = l_bit;
        end
        if (bit_cnt_q == '0) begin
          res_d   = gt_d;
          state_d = pfd_pkg::S_DONE;
        end else begin
          bit_cnt_d = bit_cnt_q - 1'b1;
        end
      end
      pfd_pkg::S_DONE: begin
        if (out_load) begin
          state_d = pfd_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = pfd_pkg::S_IDLE;
      end
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pfd_pkg::S_IDLE;
      thr_q       <= pfd_pkg::THR_RESET;
      slot_q      <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        thr_q <= cfg_data_i;
      end
    end
  end

  // datapath and result payload
  always_ff @(posedge clk_i) begin
    iv_q      <= iv_d;
    k_q       <= k_d;
    ml_q      <= ml_d;
    accl_q    <= accl_d;
    mr_q      <= mr_d;
    accr_q    <= accr_d;
    gt_q      <= gt_d;
    bit_cnt_q <= bit_cnt_d;
    res_q     <= res_d;
    if (out_load) begin
      suspect_q <= res_q;
      held_q    <= count_q;
    end
  end

endmodule
